// File: hw/rtl/tddf_pkg.sv
package tddf_pkg;

  localparam int CoordW    = 11;
  localparam int PixW      = 8;
  localparam int SumW      = 10;
  localparam int SizeW     = 12;
  localparam int OffW      = 10;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 12;
  localparam int InTdataW  = 8;
  localparam int OutTdataW = 32;

  localparam logic [SizeW-1:0] WidthRst  = 12'd1920;
  localparam logic [SizeW-1:0] HeightRst = 12'd1080;
  localparam logic [OffW-1:0]  OffsetRst = 10'd16;
  localparam int               MinSize   = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CfgFrameWidth  = 2'd0,
    CfgFrameHeight = 2'd1,
    CfgDecayOffset = 2'd2
  } cfg_idx_e;

  // one accepted pixel, as seen by the stencil stage
  typedef struct packed {
    logic [CoordW-1:0] row_a;      // row of the stencil result (y-1)
    logic [CoordW-1:0] row_b;      // own row, used on the final row
    logic [CoordW-1:0] col;
    logic [PixW-1:0]   pixel;
    logic [PixW-1:0]   prev_first; // column 0 of the row above
    logic              emit_a;
    logic              interior;
    logic              last_row;
    logic              first_col;
  } item_t;

  // up to two results of one pixel
  typedef struct packed {
    logic [CoordW-1:0] row_a;
    logic [CoordW-1:0] row_b;
    logic [CoordW-1:0] col;
    logic [PixW-1:0]   value;
    logic              has_a;
    logic              has_b;
  } res_t;

endpackage

// File: hw/rtl/tddf_ram.sv
module tddf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // read returns the old content on a same-address write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

// File: hw/rtl/tddf_raster.sv
module tddf_raster #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               accept_i,
  input  logic [tddf_pkg::PixW-1:0]          pixel_i,
  input  logic [tddf_pkg::SizeW-1:0]         frame_width_i,
  input  logic [tddf_pkg::SizeW-1:0]         frame_height_i,
  output tddf_pkg::item_t                    item_o,
  output logic [$clog2(MAX_WIDTH):0]         cur_addr_o,
  output logic [$clog2(MAX_WIDTH):0]         prev_addr_o
);
  import tddf_pkg::*;

  localparam int ColW  = $clog2(MAX_WIDTH);
  localparam int RowW  = $clog2(MAX_HEIGHT);
  localparam int WCmpW = (ColW + 1 > SizeW) ? ColW + 1 : SizeW;
  localparam int HCmpW = (RowW + 1 > SizeW) ? RowW + 1 : SizeW;

  logic [ColW-1:0]  col_q, col_d;
  logic [RowW-1:0]  row_q, row_d;
  logic [PixW-1:0]  first_q;

  logic [WCmpW-1:0] fw, w;
  logic [HCmpW-1:0] fh, h;
  logic             wrap_col;
  logic [HCmpW-1:0] y_full, y_norm;
  logic [ColW-1:0]  x;
  logic [RowW-1:0]  y;
  logic             x_last, y_last;

  // clamp the frame size into [3, MAX]
  always_comb begin
    fw = WCmpW'(frame_width_i);
    fh = HCmpW'(frame_height_i);
    if (fw < WCmpW'(MinSize)) begin
      w = WCmpW'(MinSize);
    end else if (fw > WCmpW'(MAX_WIDTH)) begin
      w = WCmpW'(MAX_WIDTH);
    end else begin
      w = fw;
    end
    if (fh < HCmpW'(MinSize)) begin
      h = HCmpW'(MinSize);
    end else if (fh > HCmpW'(MAX_HEIGHT)) begin
      h = HCmpW'(MAX_HEIGHT);
    end else begin
      h = fh;
    end
  end

  // position of this pixel; folds in a size change since the last pixel
  always_comb begin
    wrap_col = WCmpW'(col_q) >= w;
    y_full   = wrap_col ? HCmpW'(row_q) + HCmpW'(1) : HCmpW'(row_q);
    y_norm   = (y_full >= h) ? '0 : y_full;
    y        = RowW'(y_norm);
    x        = wrap_col ? '0 : col_q;
    x_last   = WCmpW'(x) == (w - WCmpW'(1));
    y_last   = HCmpW'(y) == (h - HCmpW'(1));
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept_i) begin
      if (x_last) begin
        col_d = '0;
        row_d = y_last ? '0 : RowW'(HCmpW'(y) + HCmpW'(1));
      end else begin
        col_d = ColW'(WCmpW'(x) + WCmpW'(1));
        row_d = y;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && (x == '0)) begin
      first_q <= pixel_i;
    end
  end

  always_comb begin
    item_o.row_b      = CoordW'(y);
    item_o.row_a      = CoordW'(y) - CoordW'(1);
    item_o.col        = CoordW'(x);
    item_o.pixel      = pixel_i;
    item_o.prev_first = first_q;
    item_o.emit_a     = y != '0;
    item_o.interior   = (HCmpW'(y) >= HCmpW'(2)) && (x != '0) && !x_last;
    item_o.last_row   = y_last;
    item_o.first_col  = x == '0;
  end

  // bank of row y holds row y-2; the other bank holds row y-1
  assign cur_addr_o  = {y[0], x};
  assign prev_addr_o = {~y[0], ColW'(WCmpW'(x) + WCmpW'(1))};

  a_col_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i |-> (WCmpW'(x) < w) && (HCmpW'(y) < h))
    else $error("raster position outside frame");

endmodule

// File: hw/rtl/tddf_stencil.sv
module tddf_stencil (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        load_i,
  input  logic                        adv_i,
  input  tddf_pkg::item_t             item_i,
  input  logic [tddf_pkg::PixW-1:0]   up_i,
  input  logic [tddf_pkg::PixW-1:0]   right_i,
  input  logic [tddf_pkg::OffW-1:0]   decay_offset_i,
  output logic                        valid_o,
  output tddf_pkg::res_t              res_o
);
  import tddf_pkg::*;

  item_t            s1_q;
  logic             valid_q, valid_d;
  logic [PixW-1:0]  win_a_q, win_b_q;   // row above at x and x-1
  logic [SumW-1:0]  sum, diff;
  logic [PixW-1:0]  value;

  assign valid_d = load_i ? 1'b1 : (adv_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      s1_q <= item_i;
    end
    if (valid_q && adv_i) begin
      win_b_q <= s1_q.first_col ? s1_q.prev_first : win_a_q;
      win_a_q <= right_i;
    end
  end

  always_comb begin
    sum   = SumW'(up_i) + SumW'(s1_q.pixel) + SumW'(win_b_q) + SumW'(right_i);
    diff  = sum - SumW'(decay_offset_i);
    value = '0;
    if (s1_q.interior && (sum > SumW'(decay_offset_i))) begin
      value = PixW'(diff >> 2);
    end
  end

  always_comb begin
    res_o.row_a = s1_q.row_a;
    res_o.row_b = s1_q.row_b;
    res_o.col   = s1_q.col;
    res_o.value = value;
    res_o.has_a = s1_q.emit_a;
    res_o.has_b = s1_q.last_row;
  end

  assign valid_o = valid_q;

endmodule

// File: hw/rtl/tddf_out.sv
module tddf_out (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  input  tddf_pkg::res_t                   res_i,
  output logic                             ready_o,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [tddf_pkg::OutTdataW-1:0]   m_axis_tdata,
  output logic                             m_axis_tlast
);
  import tddf_pkg::*;

  res_t              r_q;
  logic              pend_a_q, pend_b_q;
  logic              load, xfer;
  logic [CoordW-1:0] row_sel;
  logic [PixW-1:0]   value_sel;

  // room for a new pixel: empty, or the only pending result leaves now
  assign ready_o = !(pend_a_q || pend_b_q) || (m_axis_tready && (pend_a_q ^ pend_b_q));
  assign load    = valid_i && ready_o;
  assign xfer    = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_a_q <= 1'b0;
      pend_b_q <= 1'b0;
    end else if (load) begin
      pend_a_q <= res_i.has_a;
      pend_b_q <= res_i.has_b;
    end else if (xfer) begin
      if (pend_a_q) begin
        pend_a_q <= 1'b0;
      end else begin
        pend_b_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      r_q <= res_i;
    end
  end

  assign row_sel   = pend_a_q ? r_q.row_a : r_q.row_b;
  assign value_sel = pend_a_q ? r_q.value : '0;

  assign m_axis_tvalid = pend_a_q || pend_b_q;
  assign m_axis_tlast  = pend_a_q ? !pend_b_q : 1'b1;
  assign m_axis_tdata  = {(OutTdataW - 2 * CoordW - PixW)'(0), value_sel, r_q.col, row_sel};

  a_final_has_stencil: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && res_i.has_b) |-> res_i.has_a)
    else $error("final-row pixel without stencil result");

  a_pair_in_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (xfer && pend_a_q && pend_b_q) |=> (!pend_a_q && pend_b_q))
    else $error("second result of a pair lost or reordered");

endmodule

// File: hw/rtl/trail_diffuse_decay_filter.sv
// Four-neighbour diffusion and decay filter over a raster pixel stream. Each
// pixel (x,y) with y >= 1 yields the filtered pixel (x,y-1): the sum of its up,
// down, left and right neighbours less decay_offset, divided by four, or zero
// when the sum does not exceed the offset; frame border pixels give zero.
// Pixels of the final row yield a second result, (x,y) with value zero, and
// tlast marks the last result of each pixel. Throughput is one pixel per clock
// while m_axis_tready is high and outside the final row, whose pixels send both
// results through the one output register. Results pass the stencil register
// and then the output register. The two previous rows live in one line-buffer
// RAM of two banks, each MAX_WIDTH rounded up to a power of two bytes, with one
// write and two read ports; it needs no clearing after reset. Write the
// configuration only while the block is idle.
module trail_diffuse_decay_filter #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [tddf_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [tddf_pkg::CfgDataW-1:0]     cfg_data_i,
  // pixel input
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [tddf_pkg::InTdataW-1:0]     s_axis_tdata,  // [7:0] pixel_in
  // filtered output
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [10:0] out_row, [21:11] out_col, [29:22] out_value, [31:30] zero
  output logic [tddf_pkg::OutTdataW-1:0]    m_axis_tdata,
  output logic                              m_axis_tlast   // out_last
);
  import tddf_pkg::*;

  localparam int AddrW = $clog2(MAX_WIDTH) + 1;

  logic [SizeW-1:0] frame_width_q, frame_height_q;
  logic [OffW-1:0]  decay_offset_q;

  logic             accept;
  logic             s1_valid, s2_ready;
  item_t            item;
  res_t             res;
  logic [AddrW-1:0] cur_addr, prev_addr;
  logic [PixW-1:0]  up_rd, right_rd;

  // configuration registers; writes are always taken
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= WidthRst;
      frame_height_q <= HeightRst;
      decay_offset_q <= OffsetRst;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgFrameWidth:  frame_width_q  <= cfg_data_i;
        CfgFrameHeight: frame_height_q <= cfg_data_i;
        CfgDecayOffset: decay_offset_q <= cfg_data_i[OffW-1:0];
        default: ;
      endcase
    end
  end

  // the whole pipe moves when the stencil stage is empty or can hand off
  assign s_axis_tready = !s1_valid || s2_ready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  tddf_raster #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_raster (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .pixel_i        (s_axis_tdata[PixW-1:0]),
    .frame_width_i  (frame_width_q),
    .frame_height_i (frame_height_q),
    .item_o         (item),
    .cur_addr_o     (cur_addr),
    .prev_addr_o    (prev_addr)
  );

  // up: row y-2 at x (read before this pixel overwrites it)
  // right: row y-1 at x+1
  // bank select sits on the top address bit, so each bank spans a power of two
  tddf_ram #(
    .WIDTH (PixW),
    .DEPTH (2 ** AddrW)
  ) u_line_buf (
    .clk_i     (clk_i),
    .we_i      (accept),
    .waddr_i   (cur_addr),
    .wdata_i   (s_axis_tdata[PixW-1:0]),
    .re_i      (accept),
    .raddr_a_i (cur_addr),
    .raddr_b_i (prev_addr),
    .rdata_a_o (up_rd),
    .rdata_b_o (right_rd)
  );

  tddf_stencil u_stencil (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (accept),
    .adv_i          (s2_ready),
    .item_i         (item),
    .up_i           (up_rd),
    .right_i        (right_rd),
    .decay_offset_i (decay_offset_q),
    .valid_o        (s1_valid),
    .res_o          (res)
  );

  tddf_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (s1_valid),
    .res_i         (res),
    .ready_o       (s2_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // a stalled stencil stage must keep its line-buffer read data
  a_rd_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid && !s2_ready) |=> ($stable(up_rd) && $stable(right_rd)))
    else $error("line buffer read data changed under stall");

endmodule

// File: tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tddf_pkg::*;

  localparam int MaxWidth     = 2048;
  localparam int MaxHeight    = 2048;
  localparam int RandomPixels = 700;
  localparam int DrainCycles  = 8;
  localparam int CycleLimit   = 1000000;
  localparam int ReportLimit  = 10;

  // one filtered output pixel, fields as they sit in m_axis_tdata plus tlast
  typedef struct packed {
    logic [CoordW-1:0] row;
    logic [CoordW-1:0] col;
    logic [PixW-1:0]   value;
    logic              last;
  } pix_res_t;

  typedef enum logic {
    RowPixel,
    RowConfig
  } stim_kind_e;

  // one line of the directed table: a register write or a pixel transfer,
  // with the stencil value typed in where it is obvious
  typedef struct packed {
    stim_kind_e       kind;
    cfg_idx_e         idx;
    logic [11:0]      data;
    logic             has_val;
    logic [PixW-1:0]  val;
  } stim_row_t;

  typedef enum logic [1:0] {
    TrafficFree,
    TrafficSendIdle,
    TrafficRecvStall,
    TrafficBoth
  } traffic_mode_e;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index_i;
  logic [CfgDataW-1:0]  cfg_data_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [OutTdataW-1:0] m_axis_tdata;
  logic                 m_axis_tlast;

  // filter state as the testbench sees it
  logic [PixW-1:0]  line_buf [2*MaxWidth];
  logic [SizeW-1:0] cfg_width;
  logic [SizeW-1:0] cfg_height;
  logic [OffW-1:0]  cfg_offset;
  int unsigned      col_pos;
  int unsigned      row_pos;

  pix_res_t    expected_pixels [$];
  int unsigned mismatch_count;
  int unsigned cycle_count;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  stim_row_t directed_rows [22];

  trail_diffuse_decay_filter #(
    .MAX_WIDTH  (MaxWidth),
    .MAX_HEIGHT (MaxHeight)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  // sink backpressure, redrawn every cycle
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // sizes below 3 act as 3, sizes above the maximum act as the maximum
  function automatic int unsigned eff_size(input logic [SizeW-1:0] v, input int unsigned maxv);
    if (v < MinSize) return MinSize;
    if (v > maxv) return maxv;
    return v;
  endfunction

  // Advance the raster position by one pixel and queue what it yields: the
  // stencil result for the row above (from row 1 on), then on the final row
  // the pixel's own zero result. typed_val overrides the stencil value.
  task automatic predict_filter_pixel(input logic [PixW-1:0] p, input logic has_typed,
                                      input logic [PixW-1:0] typed_val);
    int unsigned w, h, x, y, sum, cur, prv;
    pix_res_t    res;
    logic [PixW-1:0] v;
    w = eff_size(cfg_width, MaxWidth);
    h = eff_size(cfg_height, MaxHeight);
    // sizes may have shrunk since the last pixel
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= h) row_pos = 0;
    x   = col_pos;
    y   = row_pos;
    cur = (y % 2) * MaxWidth;        // bank holding rows y and y-2
    prv = ((y + 1) % 2) * MaxWidth;  // bank holding row y-1
    if (y >= 1) begin
      v = '0;
      if (y - 1 != 0 && x != 0 && x != w - 1) begin
        sum = line_buf[cur+x] + p + line_buf[prv+x-1] + line_buf[prv+x+1];
        if (sum > cfg_offset) v = PixW'((sum - cfg_offset) >> 2);
      end
      if (has_typed) v = typed_val;
      res.row   = CoordW'(y - 1);
      res.col   = CoordW'(x);
      res.value = v;
      res.last  = (y != h - 1);
      expected_pixels.push_back(res);
    end
    line_buf[cur+x] = p;
    if (y == h - 1) begin
      res.row   = CoordW'(y);
      res.col   = CoordW'(x);
      res.value = '0;
      res.last  = 1'b1;
      expected_pixels.push_back(res);
    end
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) row_pos = 0;
    end
  endtask

  task automatic set_traffic(input traffic_mode_e mode);
    case (mode)
      TrafficFree: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      TrafficSendIdle: begin
        send_idle_pct  = 71;
        recv_stall_pct = 0;
      end
      TrafficRecvStall: begin
        send_idle_pct  = 0;
        recv_stall_pct = 71;
      end
      default: begin
        send_idle_pct  = 30;
        recv_stall_pct = 30;
      end
    endcase
  endtask

  // Called just after a falling edge; returns just after one. tvalid stays
  // high after the transfer so back-to-back pixels never toggle it.
  task automatic send_pixel(input logic [PixW-1:0] p, input logic has_typed,
                            input logic [PixW-1:0] typed_val);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= p;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_filter_pixel(p, has_typed, typed_val);
    @(negedge clk_i);
  endtask

  // Let every queued result come out, then allow the pipeline to settle.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_pixels.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // Register writes only ever happen with the filter idle.
  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] data);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CfgFrameWidth:  cfg_width  = data;
      CfgFrameHeight: cfg_height = data;
      CfgDecayOffset: cfg_offset = data[OffW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [PixW-1:0] pick_pixel();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return PixW'($urandom_range(0, 255));
    endcase
  endfunction

  // one whole frame at the current sizes, so the counters end on a frame wrap
  task automatic send_frame(inout int unsigned sent);
    int unsigned total;
    total = eff_size(cfg_width, MaxWidth) * eff_size(cfg_height, MaxHeight);
    repeat (total) send_pixel(pick_pixel(), 1'b0, '0);
    sent += total;
  endtask

  task automatic flag_mismatch(input string what, input pix_res_t want, input pix_res_t got,
                               input logic [1:0] pad);
    mismatch_count++;
    if (mismatch_count <= ReportLimit)
      $display({"%0t %s: expected row %0d col %0d value %0d last %0b, ",
                "got row %0d col %0d value %0d last %0b pad %0b"},
               $realtime, what, want.row, want.col, want.value, want.last,
               got.row, got.col, got.value, got.last, pad);
  endtask

  // Output checker: every result transfer is matched against the oldest
  // expectation, field by field; the two pad bits of tdata must be zero.
  always @(posedge clk_i) begin
    pix_res_t got, want;
    logic [1:0] pad;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.row   = m_axis_tdata[10:0];
      got.col   = m_axis_tdata[21:11];
      got.value = m_axis_tdata[29:22];
      got.last  = m_axis_tlast;
      pad       = m_axis_tdata[31:30];
      if (expected_pixels.size() == 0) begin
        flag_mismatch("unexpected result", '0, got, pad);
      end else begin
        want = expected_pixels.pop_front();
        if (got.row != want.row || got.col != want.col || got.value != want.value ||
            got.last != want.last || pad != 2'b00)
          flag_mismatch("result mismatch", want, got, pad);
      end
    end
  end

  // watchdog against a hung handshake or a missing result
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("[trail_diffuse_decay_filter] ERROR");
      $finish;
    end
  end

  initial begin
    int unsigned pixels_sent;
    int unsigned phase;
    int unsigned settle;
    int unsigned r;

    rst_ni         = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = CfgFrameWidth;
    cfg_data_i     = '0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    m_axis_tready  = 1'b0;
    mismatch_count = 0;
    cycle_count    = 0;
    pixels_sent    = 0;
    phase          = 0;
    cfg_width      = WidthRst;
    cfg_height     = HeightRst;
    cfg_offset     = OffsetRst;
    col_pos        = 0;
    row_pos        = 0;
    foreach (line_buf[i]) line_buf[i] = '0;
    set_traffic(TrafficFree);

    // Directed part. Width 2 and height 0 are below the minimum and act as a
    // 3x3 frame. Frame one with offset 0: a bright ring around a dark centre
    // gives the largest value, 255, at the one interior pixel. Frame two with
    // offset 1020: a neighbour sum equal to the offset yields zero.
    directed_rows = '{
      '{RowConfig, CfgFrameWidth,  12'd2,    1'b0, 8'd0},
      '{RowConfig, CfgFrameHeight, 12'd0,    1'b0, 8'd0},
      '{RowConfig, CfgDecayOffset, 12'd0,    1'b0, 8'd0},
      '{RowPixel,  CfgFrameWidth,  12'd255,  1'b0, 8'd0},   // first row: no results
      '{RowPixel,  CfgFrameWidth,  12'd255,  1'b0, 8'd0},
      '{RowPixel,  CfgFrameWidth,  12'd255,  1'b0, 8'd0},
      '{RowPixel,  CfgFrameWidth,  12'd255,  1'b1, 8'd0},   // top border row comes out
      '{RowPixel,  CfgFrameWidth,  12'd0,    1'b1, 8'd0},
      '{RowPixel,  CfgFrameWidth,  12'd255,  1'b1, 8'd0},
      '{RowPixel,  CfgFrameWidth,  12'd255,  1'b1, 8'd0},   // final row: two results each
      '{RowPixel,  CfgFrameWidth,  12'd255,  1'b1, 8'd255},
      '{RowPixel,  CfgFrameWidth,  12'd255,  1'b1, 8'd0},   // frame wraps after this
      '{RowConfig, CfgDecayOffset, 12'd1020, 1'b0, 8'd0},
      '{RowPixel,  CfgFrameWidth,  12'd255,  1'b0, 8'd0},
      '{RowPixel,  CfgFrameWidth,  12'd255,  1'b0, 8'd0},
      '{RowPixel,  CfgFrameWidth,  12'd255,  1'b0, 8'd0},
      '{RowPixel,  CfgFrameWidth,  12'd255,  1'b1, 8'd0},
      '{RowPixel,  CfgFrameWidth,  12'd255,  1'b1, 8'd0},
      '{RowPixel,  CfgFrameWidth,  12'd255,  1'b1, 8'd0},
      '{RowPixel,  CfgFrameWidth,  12'd255,  1'b1, 8'd0},
      '{RowPixel,  CfgFrameWidth,  12'd255,  1'b1, 8'd0},   // sum 1020 not above offset
      '{RowPixel,  CfgFrameWidth,  12'd255,  1'b1, 8'd0}
    };

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == RowConfig)
        write_reg(directed_rows[i].idx, directed_rows[i].data);
      else
        send_pixel(directed_rows[i].data[PixW-1:0], directed_rows[i].has_val,
                   directed_rows[i].val);
    end

    // Random part: small frames under rotating traffic, new sizes and offset
    // per phase; now and then a size below the minimum or a high offset.
    while (pixels_sent < RandomPixels) begin
      set_traffic(traffic_mode_e'(phase % 4));
      r = $urandom_range(0, 15);
      write_reg(CfgFrameWidth, (r == 0) ? CfgDataW'($urandom_range(0, 2)) :
                                          CfgDataW'($urandom_range(3, 10)));
      r = $urandom_range(0, 15);
      write_reg(CfgFrameHeight, (r == 0) ? CfgDataW'($urandom_range(0, 2)) :
                                           CfgDataW'($urandom_range(3, 6)));
      case ($urandom_range(0, 7))
        0:       write_reg(CfgDecayOffset, CfgDataW'($urandom_range(600, 1023)));
        1:       write_reg(CfgDecayOffset, CfgDataW'(0));
        default: write_reg(CfgDecayOffset, CfgDataW'($urandom_range(0, 300)));
      endcase
      repeat ($urandom_range(1, 3)) send_frame(pixels_sent);
      phase++;
    end

    // wind down: bounded wait for outstanding results, then settle
    s_axis_tvalid <= 1'b0;
    settle = 0;
    while (expected_pixels.size() != 0 && settle < 5000) begin
      @(negedge clk_i);
      settle++;
    end
    repeat (DrainCycles) @(negedge clk_i);
    mismatch_count += expected_pixels.size();

    if (mismatch_count == 0) begin
      $display("[trail_diffuse_decay_filter] OK");
    end else begin
      $display("[trail_diffuse_decay_filter] ERROR");
    end
    $finish;
  end

endmodule
